### src/sbcr_pkg.sv
// sbcr_pkg: shared types and constants for the save block chain reader
// no dependencies
`default_nettype none
package sbcr_pkg;
    localparam int NUM_BLOCKS  = 512;
    localparam int BLOCK_BYTES = 64;
    localparam int MAX_CHAIN   = 512;
    localparam int AW   = 15;
    localparam int BW   = $clog2(NUM_BLOCKS);
    localparam int OW   = $clog2(BLOCK_BYTES);
    localparam int CW   = $clog2(MAX_CHAIN);
    localparam int CCW  = CW + 1;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOTFND  = 2'd1;
    localparam logic [1:0] ST_NODATA  = 2'd2;

    localparam logic [7:0] SIZE_OFS   = 8'h1e;
    localparam logic [7:0] INLINE_MAX = 8'h1e;
    localparam logic [7:0] DATA_OFS   = 8'h22;
    localparam logic [7:0] LINK_OFS   = 8'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK,
        S_SIZE_RD, S_SIZE_CHK,
        S_LIST_RD, S_LIST_CHK,
        S_LINK_RD, S_LINK_WAIT, S_LINK_LOAD,
        S_CUR_RD, S_CUR_WAIT,
        S_FETCH_RD, S_FETCH_CHK,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       wr_img;
        logic       rd_img;   // read at image address from addr_sel
        logic [2:0] addr_sel; // 0 scan, 1 size, 2 list, 3 fetch
        logic [2:0] byte_idx; // byte counter for multi-byte reads
        logic       rd_chain; // read chain at pos (link)
        logic       rd_chain_cur;
        logic       scan_init;
        logic       scan_next;
        logic       found_inc;
        logic       size_load;
        logic       list_push;
        logic       list_adv;
        logic       link_load;
        logic       list_term;
        logic       open_done;
        logic       open_fail;
        logic       cur_load;
        logic       fetch_adv;
        logic       shift_in;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_is_open;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic mark_ok;
        logic found_hit;
        logic inline_size;
        logic capped;
        logic entry_zero;
        logic dp_wrap;
        logic pending;
        logic fetch_wrap;
    } t_sts;
endpackage
`default_nettype wire

### src/save_block_chain_reader.sv
// save_block_chain_reader: top level, controller plus datapath
// open: scans header blocks from block 2, reads and clamps the size, then unless
// inline walks the list, loading the next list block at block end, then the result
// fetch: reads the current block from the chain and two data bytes, then the result;
// write: no result; one request at a time, results in request order
// synchronous active-low reset clears control, memories keep contents
`default_nettype none
module save_block_chain_reader
    import sbcr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_cmd,
    input  wire  [14:0] i_mem_addr,
    input  wire  [7:0]  i_mem_byte,
    input  wire  [8:0]  i_save_index,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_data_word,
    output logic [14:0] o_data_size,
    output logic        o_last
);
    t_cmd cmd;
    t_sts sts;

    sbcr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd_code(i_cmd), .o_valid(o_valid), .i_out_ready(i_ready),
        .o_cmd(cmd), .i_sts(sts)
    );

    sbcr_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_mem_addr(i_mem_addr), .i_mem_byte(i_mem_byte), .i_save_index(i_save_index),
        .o_status(o_status), .o_data_word(o_data_word), .o_data_size(o_data_size),
        .o_last(o_last)
    );
endmodule
`default_nettype wire

### src/sbcr_ram.sv
// sbcr_ram: generic single-port RAM, registered read
// no dependencies
`default_nettype none
module sbcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### src/sbcr_datapath.sv
// sbcr_datapath: image and chain memories, walk pointers, fetch state, result register
// depends on sbcr_pkg, sbcr_ram
`default_nettype none
module sbcr_datapath
    import sbcr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  wire  [AW-1:0] i_mem_addr,
    input  wire  [7:0]  i_mem_byte,
    input  wire  [8:0]  i_save_index,
    output logic [1:0]  o_status,
    output logic [15:0] o_data_word,
    output logic [14:0] o_data_size,
    output logic        o_last
);
    logic [BW-1:0]  r_scan_blk, r_start;
    logic [8:0]     r_found;
    logic [8:0]     r_want;
    logic [31:0]    r_sh;
    logic [14:0]    r_size;
    logic [BW-1:0]  r_blk;
    logic [OW:0]    r_dp;
    logic [CCW-1:0] r_pos, r_count;
    logic [CCW-1:0] r_npos;
    logic [OW:0]    r_boff;
    logic [15:0]    r_left;
    logic [BW-1:0]  r_cur;
    logic           r_open;
    logic [OW:0]    n_dp;

    // image address select
    logic [OW:0]  ofs;
    logic [BW-1:0] ablk;
    logic [AW-1:0] img_addr;
    logic [7:0]   img_q;
    logic [31:0]  blk_base;
    always_comb begin
        unique case (i_cmd.addr_sel)
            3'd0:    begin ablk = r_scan_blk; ofs = (OW+1)'(i_cmd.byte_idx); end
            3'd1:    begin ablk = r_start; ofs = (OW+1)'(SIZE_OFS) + (OW+1)'(i_cmd.byte_idx); end
            3'd2:    begin ablk = r_blk; ofs = r_dp + (OW+1)'(i_cmd.byte_idx); end
            default: begin ablk = r_cur; ofs = r_boff + (OW+1)'(i_cmd.byte_idx); end
        endcase
        blk_base = 32'(ablk) * 32'(BLOCK_BYTES) + 32'(ofs);
        img_addr = i_cmd.wr_img ? i_mem_addr : blk_base[AW-1:0];
    end

    sbcr_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_img (
        .i_clk(i_clk), .i_we(i_cmd.wr_img), .i_addr(img_addr),
        .i_wdata(i_mem_byte), .o_rdata(img_q)
    );

    // chain memory, entry 0 is the start block, list entries come from the image byte pair
    logic [CW-1:0] ch_addr;
    logic [8:0]    ch_q, ch_wd;
    logic          ch_we;
    logic [CCW-1:0] ch_pos;
    logic           r_ch_valid;
    always_comb begin
        ch_we  = i_cmd.list_push | i_cmd.size_load;
        ch_wd  = i_cmd.size_load ? 9'(r_scan_blk) : {r_sh[0], img_q};
        ch_pos = i_cmd.rd_chain_cur ? (r_npos - 1'b1) : (i_cmd.rd_chain ? r_pos : r_count);
        if (i_cmd.size_load) ch_pos = '0;
        ch_addr = ch_pos[CW-1:0];
    end
    sbcr_ram #(.WIDTH(9), .DEPTH(MAX_CHAIN)) u_chain (
        .i_clk(i_clk), .i_we(ch_we), .i_addr(ch_addr), .i_wdata(ch_wd), .o_rdata(ch_q)
    );
    logic [BW-1:0] ch_blk;
    assign ch_blk = r_ch_valid ? BW'(ch_q) : '0;

    // status to controller
    always_comb begin
        n_dp = r_dp + (OW+1)'(2);
        o_sts.scan_end   = (32'(r_scan_blk) == 32'(NUM_BLOCKS - 1));
        o_sts.mark_ok    = (r_sh == 32'h80000000);
        o_sts.found_hit  = (r_found == r_want);
        o_sts.inline_size = (r_size <= 15'(INLINE_MAX));
        o_sts.capped     = (32'(r_count) >= 32'(MAX_CHAIN));
        o_sts.entry_zero = ({r_sh[7:0], img_q} == 16'd0);
        o_sts.dp_wrap    = (32'(n_dp) >= 32'(BLOCK_BYTES));
        o_sts.pending    = r_open && (r_left != 16'd0);
        o_sts.fetch_wrap = (32'(r_boff) + 32'd2 >= 32'(BLOCK_BYTES));
    end

    // walk and fetch registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0; r_left <= '0; r_boff <= '0; r_cur <= '0;
            r_npos <= '0; r_count <= '0; r_ch_valid <= 1'b0;
        end else begin
            r_ch_valid <= (ch_pos < r_count) && (32'(ch_pos) < 32'(MAX_CHAIN));
            if (i_cmd.shift_in) r_sh <= {r_sh[23:0], img_q};
            if (i_cmd.scan_init) begin
                r_scan_blk <= BW'(2); r_found <= '0; r_want <= i_save_index;
            end
            if (i_cmd.scan_next) r_scan_blk <= r_scan_blk + 1'b1;
            if (i_cmd.found_inc) r_found <= r_found + 1'b1;
            if (i_cmd.size_load) begin
                r_start <= r_scan_blk; r_blk <= r_scan_blk;
                r_size <= (r_sh > 32'h7fff) ? 15'h7fff : r_sh[14:0];
                r_dp <= (OW+1)'(DATA_OFS); r_pos <= CCW'(1); r_count <= CCW'(1);
            end
            if (i_cmd.list_push) r_count <= r_count + 1'b1;
            if (i_cmd.list_adv) begin
                r_dp <= n_dp;
            end
            if (i_cmd.link_load) begin
                r_blk <= ch_blk; r_pos <= r_pos + 1'b1; r_dp <= (OW+1)'(LINK_OFS);
            end
            if (i_cmd.list_term) begin
                if (32'(n_dp) >= 32'(BLOCK_BYTES)) begin
                    r_pos <= r_pos + 1'b1; r_dp <= (OW+1)'(LINK_OFS);
                end else r_dp <= n_dp;
            end
            if (i_cmd.open_done) begin
                r_npos <= r_pos; r_boff <= r_dp; r_left <= 16'(r_size); r_open <= 1'b1;
            end
            if (i_cmd.open_fail) r_open <= 1'b0;
            if (i_cmd.cur_load) r_cur <= ch_blk;
            // position stops one past the chain memory end; past the list end the block reads as 0
            if (i_cmd.fetch_adv) begin
                r_left <= (r_left > 16'd2) ? r_left - 16'd2 : 16'd0;
                if (o_sts.fetch_wrap) begin
                    r_boff <= (OW+1)'(LINK_OFS);
                    if (32'(r_npos) <= 32'(MAX_CHAIN)) r_npos <= r_npos + 1'b1;
                end else r_boff <= r_boff + (OW+1)'(2);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status    <= i_cmd.out_status;
            o_data_word <= (i_cmd.out_is_open || i_cmd.out_status != ST_OK) ? 16'd0
                           : {img_q, r_sh[7:0]};
            o_data_size <= (i_cmd.out_is_open && i_cmd.out_status == ST_OK) ? r_size : 15'd0;
            o_last      <= !i_cmd.out_is_open && i_cmd.out_status == ST_OK &&
                           (r_left <= 16'd2);
        end
    end
endmodule
`default_nettype wire

### src/sbcr_ctrl.sv
// sbcr_ctrl: command sequencer for writes, open walks and fetches
// depends on sbcr_pkg
`default_nettype none
module sbcr_ctrl
    import sbcr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [1:0] i_cmd_code,
    output logic       o_valid,
    input  wire        i_out_ready,
    output t_cmd       o_cmd,
    input  t_sts       i_sts
);
    t_state r_state, n_state;
    logic [2:0] r_bi, n_bi;
    logic [1:0] r_fix, n_fix; // step flag: 1 header check, 3 size clamp, 2 fetch advance on output

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_bi <= '0; r_fix <= '0;
        end else begin
            r_state <= n_state; r_bi <= n_bi; r_fix <= n_fix;
        end
    end

    always_comb begin
        n_state = r_state; n_bi = r_bi; n_fix = r_fix;
        o_cmd = '0; o_cmd.byte_idx = r_bi;
        o_ready = 1'b0; o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    priority case (i_cmd_code)
                        CMD_WRITE: o_cmd.wr_img = 1'b1;
                        CMD_OPEN: begin
                            o_cmd.scan_init = 1'b1; n_bi = '0; n_state = S_SCAN_RD;
                        end
                        CMD_FETCH: begin
                            n_bi = '0;
                            if (i_sts.pending) begin
                                o_cmd.rd_chain_cur = 1'b1; n_state = S_CUR_WAIT;
                            end else begin
                                o_cmd.out_load = 1'b1; o_cmd.out_status = ST_NODATA;
                                n_state = S_OUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // read four header bytes of the scanned block
            S_SCAN_RD: begin
                o_cmd.addr_sel = 3'd0; n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.shift_in = 1'b1;
                if (r_bi != 3'd3) begin
                    n_bi = r_bi + 1'b1; n_state = S_SCAN_RD;
                end else begin
                    n_bi = '0; n_state = S_SIZE_RD; n_fix = 2'd1;
                end
            end
            S_SIZE_RD: begin
                if (r_fix == 2'd1) begin
                    // decide on header word, a hit seeds the start block regs
                    n_fix = 2'd0;
                    if (i_sts.mark_ok && i_sts.found_hit) begin
                        o_cmd.size_load = 1'b1; n_state = S_SIZE_RD; n_fix = 2'd2;
                    end else begin
                        if (i_sts.mark_ok) o_cmd.found_inc = 1'b1;
                        if (i_sts.scan_end) begin
                            o_cmd.open_fail = 1'b1; o_cmd.out_load = 1'b1;
                            o_cmd.out_status = ST_NOTFND; o_cmd.out_is_open = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            o_cmd.scan_next = 1'b1; n_state = S_SCAN_RD;
                        end
                    end
                end else begin
                    o_cmd.addr_sel = 3'd1;
                    n_fix = 2'd0; n_state = S_SIZE_CHK;
                end
            end
            S_SIZE_CHK: begin
                o_cmd.shift_in = 1'b1;
                if (r_bi != 3'd3) begin
                    n_bi = r_bi + 1'b1; n_state = S_SIZE_RD;
                end else begin
                    n_bi = '0; n_state = S_LIST_RD; n_fix = 2'd3;
                end
            end
            S_LIST_RD: begin
                if (r_fix == 2'd3) begin
                    // clamp size then choose inline or list walk
                    o_cmd.size_load = 1'b1; n_fix = 2'd0;
                end else if (i_sts.inline_size || i_sts.capped) begin
                    o_cmd.open_done = 1'b1; o_cmd.out_load = 1'b1;
                    o_cmd.out_status = ST_OK; o_cmd.out_is_open = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.addr_sel = 3'd2; n_state = S_LIST_CHK;
                end
            end
            S_LIST_CHK: begin
                o_cmd.shift_in = 1'b1; o_cmd.addr_sel = 3'd2;
                if (r_bi == 3'd0) begin
                    n_bi = 3'd1; n_fix = 2'd0;
                    o_cmd.byte_idx = 3'd0;
                    n_state = S_LINK_RD;
                end else begin
                    n_bi = '0;
                    if (i_sts.entry_zero) begin
                        o_cmd.list_term = 1'b1;
                        n_state = S_CUR_RD;
                    end else begin
                        o_cmd.list_push = 1'b1; o_cmd.list_adv = 1'b1;
                        if (i_sts.dp_wrap) n_state = S_LINK_WAIT;
                        else n_state = S_LIST_RD;
                    end
                end
            end
            // second byte read of a list entry
            S_LINK_RD: begin
                o_cmd.addr_sel = 3'd2; o_cmd.byte_idx = 3'd1; n_state = S_LIST_CHK;
            end
            // next list block: read its number from the chain, then load it
            S_LINK_WAIT: begin
                o_cmd.rd_chain = 1'b1; n_state = S_LINK_LOAD;
            end
            S_LINK_LOAD: begin
                o_cmd.link_load = 1'b1; n_state = S_LIST_RD;
            end
            // finish open after terminator
            S_CUR_RD: begin
                o_cmd.open_done = 1'b1; o_cmd.out_load = 1'b1;
                o_cmd.out_status = ST_OK; o_cmd.out_is_open = 1'b1;
                n_state = S_OUT;
            end
            // fetch: current block from chain, two bytes
            S_CUR_WAIT: begin
                o_cmd.cur_load = 1'b1; n_state = S_FETCH_RD;
            end
            S_FETCH_RD: begin
                o_cmd.addr_sel = 3'd3; n_state = S_FETCH_CHK;
            end
            S_FETCH_CHK: begin
                o_cmd.shift_in = 1'b1; o_cmd.addr_sel = 3'd3;
                if (r_bi == 3'd0) begin
                    n_bi = 3'd1; n_state = S_FETCH_RD;
                end else begin
                    n_bi = '0; o_cmd.out_load = 1'b1; o_cmd.out_status = ST_OK;
                    n_state = S_OUT; n_fix = 2'd2;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (r_fix == 2'd2) begin
                    o_cmd.fetch_adv = 1'b1; n_fix = 2'd0;
                end
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
